// ===== src/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath bundles for the max-heap queue
// no dependencies

package mhpq_pkg;

  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd1;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    RD_ROOT,
    RD_PARENT,
    RD_CHILD
  } rd_sel_t;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_ZERO,
    RES_FULL,
    RES_EMPTY,
    RES_ROOT
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     ins_start;
    logic     ext_start;
    logic     up_move;
    logic     dn_move;
    logic     put_key;
    rd_sel_t  rd_sel;
    res_sel_t res;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            pos_zero;
    logic            parent_less;
    logic            has_lc;
    logic            child_wins;
  } stat_t;

endpackage

// ===== src/mhpq_ifs.sv =====
`timescale 1ns / 1ps
// valid/ready channels for requests and responses of the max-heap queue
// depends on mhpq_pkg

interface mhpq_req_if;
  logic                                valid;
  logic                                ready;
  logic [mhpq_pkg::OP_W-1:0]           op;
  logic signed [mhpq_pkg::KEY_W-1:0]   key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

interface mhpq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [mhpq_pkg::KEY_W-1:0]   value;
  logic [mhpq_pkg::ST_W-1:0]           status;
  logic [mhpq_pkg::CNT_W-1:0]          count;

  modport source (output valid, output value, output status, output count, input ready);
  modport sink (input valid, input value, input status, input count, output ready);
endinterface

// ===== src/max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// binary max-heap priority queue on mhpq_pkg, mhpq_ifs, mhpq_ctrl and mhpq_dp
// an insert climbs and an extract descends one level at a time, each level paced by a
// registered read and a write of the key store; one request at a time, the next one
// taken in the cycle after its result loads; reset clears count and control, not the
// key store

module max_heap_priority_queue (
  input logic        clk,
  input logic        rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);

  mhpq_pkg::cmd_t                    cmd;
  mhpq_pkg::stat_t                   stat;
  logic                              out_load;
  logic                              out_free;
  logic                              ovalid;
  logic signed [mhpq_pkg::KEY_W-1:0] res_value;
  logic [mhpq_pkg::ST_W-1:0]         res_status;
  logic [mhpq_pkg::CNT_W-1:0]        count;

  assign out_free = !ovalid || rsp.ready;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .out_free  (out_free),
    .stat      (stat),
    .req_ready (req.ready),
    .out_load  (out_load),
    .cmd       (cmd)
  );

  mhpq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_op      (req.op),
    .in_key     (req.key),
    .stat       (stat),
    .res_value  (res_value),
    .res_status (res_status),
    .count      (count)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_load) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.value  <= res_value;
      rsp.status <= res_status;
      rsp.count  <= count;
    end
  end

  assign rsp.valid = ovalid;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while another is in flight");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == mhpq_pkg::ST_EMPTY |-> rsp.value == '1 && rsp.count == '0)
    else $error("empty response with wrong value or count");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == mhpq_pkg::ST_FULL
      |-> rsp.count == mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH))
    else $error("full response while heap not full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH))
    else $error("entry count beyond depth");

endmodule

// ===== src/mhpq_dp.sv =====
`timescale 1ns / 1ps
// heap datapath: key store, moving key, slot pointer, entry count and result
// depends on mhpq_pkg

module mhpq_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  mhpq_pkg::cmd_t                     cmd,
  input  logic [mhpq_pkg::OP_W-1:0]          in_op,
  input  logic signed [mhpq_pkg::KEY_W-1:0]  in_key,
  output mhpq_pkg::stat_t                    stat,
  output logic signed [mhpq_pkg::KEY_W-1:0]  res_value,
  output logic [mhpq_pkg::ST_W-1:0]          res_status,
  output logic [mhpq_pkg::CNT_W-1:0]         count
);

  localparam int IDX_W = mhpq_pkg::ADDR_W + 2;

  logic signed [mhpq_pkg::KEY_W-1:0] key_store [mhpq_pkg::DEPTH];
  logic signed [mhpq_pkg::KEY_W-1:0] rd_a;
  logic signed [mhpq_pkg::KEY_W-1:0] rd_b;
  logic signed [mhpq_pkg::KEY_W-1:0] key_r;
  logic [mhpq_pkg::OP_W-1:0]         op_r;
  logic [mhpq_pkg::ADDR_W-1:0]       pos;

  logic [mhpq_pkg::ADDR_W-1:0]       parent;
  logic [mhpq_pkg::ADDR_W-1:0]       last;
  logic [IDX_W-1:0]                  lc;
  logic [IDX_W-1:0]                  rc;
  logic [IDX_W-1:0]                  cnt_x;
  logic                              has_rc;
  logic                              pick_rc;
  logic signed [mhpq_pkg::KEY_W-1:0] best_val;
  logic [IDX_W-1:0]                  best_idx;
  logic [mhpq_pkg::ADDR_W-1:0]       addr_a;
  logic [mhpq_pkg::ADDR_W-1:0]       addr_b;
  logic                              wr_en;
  logic signed [mhpq_pkg::KEY_W-1:0] wr_data;

  assign parent   = mhpq_pkg::ADDR_W'(pos - 1'b1) >> 1;
  assign last     = mhpq_pkg::ADDR_W'(count - 1'b1);
  assign lc       = IDX_W'({pos, 1'b1});
  assign rc       = lc + 1'b1;
  assign cnt_x    = IDX_W'(count);
  assign has_rc   = rc < cnt_x;
  // left child wins a tie
  assign pick_rc  = has_rc && (rd_b > rd_a);
  assign best_val = pick_rc ? rd_b : rd_a;
  assign best_idx = pick_rc ? rc : lc;

  always_comb begin
    case (cmd.rd_sel)
      mhpq_pkg::RD_PARENT: begin
        addr_a = parent;
        addr_b = last;
      end
      mhpq_pkg::RD_CHILD: begin
        addr_a = lc[mhpq_pkg::ADDR_W-1:0];
        addr_b = rc[mhpq_pkg::ADDR_W-1:0];
      end
      default: begin
        addr_a = '0;
        addr_b = last;
      end
    endcase
  end

  assign wr_en   = cmd.up_move | cmd.dn_move | cmd.put_key;
  assign wr_data = cmd.up_move ? rd_a : (cmd.dn_move ? best_val : key_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_store[pos] <= wr_data;
    end
    rd_a <= key_store[addr_a];
    rd_b <= key_store[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_start) begin
      count <= count + 1'b1;
    end else if (cmd.ext_start) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      key_r <= in_key;
    end else if (cmd.ext_start) begin
      key_r <= rd_b;
    end
    if (cmd.ins_start) begin
      pos <= mhpq_pkg::ADDR_W'(count);
    end else if (cmd.ext_start) begin
      pos <= '0;
    end else if (cmd.up_move) begin
      pos <= parent;
    end else if (cmd.dn_move) begin
      pos <= best_idx[mhpq_pkg::ADDR_W-1:0];
    end
    case (cmd.res)
      mhpq_pkg::RES_ZERO: begin
        res_value  <= '0;
        res_status <= mhpq_pkg::ST_OK;
      end
      mhpq_pkg::RES_FULL: begin
        res_value  <= '0;
        res_status <= mhpq_pkg::ST_FULL;
      end
      mhpq_pkg::RES_EMPTY: begin
        res_value  <= '1;
        res_status <= mhpq_pkg::ST_EMPTY;
      end
      mhpq_pkg::RES_ROOT: begin
        res_value  <= rd_a;
        res_status <= mhpq_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  assign stat.op          = op_r;
  assign stat.full        = count == mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH);
  assign stat.empty       = count == '0;
  assign stat.pos_zero    = pos == '0;
  assign stat.parent_less = rd_a < key_r;
  assign stat.has_lc      = lc < cnt_x;
  assign stat.child_wins  = best_val > key_r;

endmodule

// ===== src/mhpq_ctrl.sv =====
`timescale 1ns / 1ps
// controller for the max-heap queue: dispatch, sift-up and sift-down sequencing
// depends on mhpq_pkg

module mhpq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            out_free,
  input  mhpq_pkg::stat_t stat,
  output logic            req_ready,
  output logic            out_load,
  output mhpq_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_RD,
    S_UP_CMP,
    S_ROOT_RD,
    S_ROOT_TAKE,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = mhpq_pkg::RD_ROOT;
    cmd.res    = mhpq_pkg::RES_HOLD;
    out_load   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.op == mhpq_pkg::OP_INSERT) begin
          if (stat.full) begin
            cmd.res    = mhpq_pkg::RES_FULL;
            state_next = S_RESP;
          end else begin
            cmd.ins_start = 1'b1;
            cmd.res       = mhpq_pkg::RES_ZERO;
            state_next    = S_UP_RD;
          end
        end else if (stat.op inside {mhpq_pkg::OP_PEEK, mhpq_pkg::OP_EXTRACT}) begin
          if (stat.empty) begin
            cmd.res    = mhpq_pkg::RES_EMPTY;
            state_next = S_RESP;
          end else begin
            state_next = S_ROOT_RD;
          end
        end else begin
          cmd.res    = mhpq_pkg::RES_ZERO;
          state_next = S_RESP;
        end
      end
      S_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.put_key = 1'b1;
          state_next  = S_RESP;
        end else begin
          cmd.rd_sel = mhpq_pkg::RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.parent_less) begin
          cmd.up_move = 1'b1;
          state_next  = S_UP_RD;
        end else begin
          cmd.put_key = 1'b1;
          state_next  = S_RESP;
        end
      end
      S_ROOT_RD: begin
        // root on port a, last entry on port b
        state_next = S_ROOT_TAKE;
      end
      S_ROOT_TAKE: begin
        cmd.res = mhpq_pkg::RES_ROOT;
        if (stat.op == mhpq_pkg::OP_EXTRACT) begin
          cmd.ext_start = 1'b1;
          state_next    = S_DN_RD;
        end else begin
          state_next = S_RESP;
        end
      end
      S_DN_RD: begin
        if (stat.has_lc) begin
          cmd.rd_sel = mhpq_pkg::RD_CHILD;
          state_next = S_DN_CMP;
        end else begin
          cmd.put_key = 1'b1;
          state_next  = S_RESP;
        end
      end
      S_DN_CMP: begin
        cmd.rd_sel = mhpq_pkg::RD_CHILD;
        if (stat.child_wins) begin
          cmd.dn_move = 1'b1;
          state_next  = S_DN_RD;
        end else begin
          cmd.put_key = 1'b1;
          state_next  = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
